/* rtl/core/mmheap_pkg.sv */
// Package for the min-max heap double-ended queue.
// Sizes, operation and status codes, payload structs. No dependencies.
`default_nettype none
package mmheap_pkg;
	localparam int unsigned Capacity = 1024;
	localparam int unsigned AddrW = $clog2(Capacity);
	localparam int unsigned PosW = AddrW + 2;
	localparam int unsigned CountW = $clog2(Capacity + 1);

	typedef logic [1:0] func_t;
	localparam func_t FuncInsert = 2'd0;
	localparam func_t FuncRemoveMax = 2'd1;
	localparam func_t FuncRemoveMin = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t StatusOk = 2'd0;
	localparam status_t StatusEmpty = 2'd1;
	localparam status_t StatusFull = 2'd2;

	typedef struct packed {
		func_t func;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] removed_value;
		status_t status;
		logic signed [31:0] min_value;
		logic signed [31:0] max_value;
		logic is_empty;
		logic [CountW-1:0] entry_count;
	} rsp_t;
endpackage
`default_nettype wire

/* rtl/core/mmheap_if.sv */
// Valid/ready channel interface carrying one payload struct.
// Depends on mmheap_pkg.
`default_nettype none
interface mmheap_req_if import mmheap_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface mmheap_rsp_if import mmheap_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/min_max_heap_double_ended_queue.sv */
// Min-max heap double-ended priority queue, top level.
// Depends on mmheap_pkg and the channel interfaces in mmheap_if.
//
// One operation at a time. Values live in one single-port RAM (one read or
// write per cycle, registered read data) plus registered copies of the
// root and its two children kept for the min/max outputs. An insert writes
// the new value at the end, checks it against its parent, then climbs the
// grandparent levels. A removal reads up to six entries per level, then does
// the swap and the parent check. A new request is accepted once the previous
// result sits in the output register; a stalled result holds the next one
// back in S_DONE.
`default_nettype none
module min_max_heap_double_ended_queue import mmheap_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	mmheap_req_if.sink in_ch,
	mmheap_rsp_if.source out_ch
);
	typedef enum logic [15:0] {
		S_IDLE = 16'h0001,
		S_RD = 16'h0002,
		S_SCAN = 16'h0008,
		S_DEC = 16'h0010,
		S_WA = 16'h0020,
		S_WB = 16'h0040,
		S_UPCHK = 16'h0080,
		S_FIXP = 16'h0100,
		S_FIXW = 16'h0200,
		S_RM0 = 16'h0400,
		S_RM1 = 16'h0800,
		S_TOP0 = 16'h1000,
		S_DONE = 16'h4000
	} state_t;

	state_t st_q, ret_q;
	logic signed [31:0] mem [Capacity];
	logic signed [31:0] rdata_s1;
	logic [AddrW-1:0] addr;
	logic we;
	logic signed [31:0] wdata;

	logic [CountW-1:0] cnt_q;
	logic [PosW-1:0] node_q, best_q, idx_q, pa_q, pb_q;
	logic signed [31:0] nv_q, bv_q, va_q, vb_q, removed_q;
	logic onmax_q, pend_q, rdpend_q;
	logic [2:0] sidx_q;
	status_t status_q;
	logic signed [31:0] top1_q, top2_q, top3_q;
	logic out_valid_q;
	rsp_t out_q;

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata_s1 <= mem[addr];
	end

	function automatic logic [AddrW-1:0] pa(input logic [PosW-1:0] p);
		return AddrW'(p - PosW'(1));
	endfunction
	function automatic logic outr(input logic signed [31:0] a, b, input logic m);
		return m ? (a < b) : (a > b);
	endfunction
	function automatic int unsigned lvl(input logic [PosW-1:0] p);
		int unsigned l;
		l = 0;
		for (int unsigned i = 0; i < PosW; i++) if (p[i]) l = i;
		return l;
	endfunction

	logic [PosW-1:0] cand;
	logic cand_ok, cand_last;
	always_comb begin
		if (sidx_q < 3'd2) cand = PosW'({node_q, 1'b0}) + PosW'(sidx_q);
		else cand = PosW'({node_q, 2'b00}) + PosW'(sidx_q - 3'd2);
		cand_ok = (cand <= PosW'(cnt_q)) && (cand != 0);
		cand_last = (sidx_q == 3'd5);
	end

	// position copies for root and children
	logic signed [31:0] tw_v;
	logic [PosW-1:0] tw_p;
	logic tw_en;
	always_ff @(posedge clk) begin
		if (tw_en) begin
			if (tw_p == PosW'(1)) top1_q <= tw_v;
			if (tw_p == PosW'(2)) top2_q <= tw_v;
			if (tw_p == PosW'(3)) top3_q <= tw_v;
		end
	end

	always_comb begin
		we = 1'b0;
		addr = pa(pa_q);
		wdata = va_q;
		tw_en = 1'b0;
		tw_p = pa_q;
		tw_v = va_q;
		case (st_q)
			S_RD: addr = pa(idx_q);
			S_WA: begin
				we = 1'b1; addr = pa(pa_q); wdata = vb_q;
				tw_en = 1'b1; tw_p = pa_q; tw_v = vb_q;
			end
			S_WB: begin
				we = 1'b1; addr = pa(pb_q); wdata = va_q;
				tw_en = 1'b1; tw_p = pb_q; tw_v = va_q;
			end
			S_RM0: addr = pa(PosW'(cnt_q));
			default: addr = pa(idx_q);
		endcase
	end

	logic [PosW-1:0] cnt_p;
	assign cnt_p = PosW'(cnt_q);

	logic out_load;
	assign out_load = (st_q == S_DONE) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ret_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			pend_q <= 1'b0;
			rdpend_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: if (in_ch.valid && in_ch.ready) begin
					case (in_ch.payload.func)
						FuncInsert: begin
							removed_q <= '0;
							if (cnt_q >= CountW'(Capacity)) begin
								status_q <= StatusFull; st_q <= S_DONE;
							end else begin
								status_q <= StatusOk;
								cnt_q <= cnt_q + 1'b1;
								pa_q <= cnt_p + 1'b1; vb_q <= in_ch.payload.value;
								pb_q <= '0;
								node_q <= cnt_p + 1'b1;
								nv_q <= in_ch.payload.value;
								st_q <= S_WA; ret_q <= S_FIXP;
							end
						end
						FuncRemoveMax, FuncRemoveMin: begin
							if (cnt_q == 0) begin
								removed_q <= '0;
								status_q <= StatusEmpty; st_q <= S_DONE;
							end else begin
								status_q <= StatusOk;
								if (in_ch.payload.func == FuncRemoveMax && cnt_q < 3) begin
									removed_q <= (cnt_q == 1) ? top1_q : top2_q;
									cnt_q <= cnt_q - 1'b1;
									st_q <= S_DONE;
								end else begin
									if (in_ch.payload.func == FuncRemoveMin) begin
										node_q <= PosW'(1); removed_q <= top1_q;
										onmax_q <= 1'b0;
									end else if (top2_q > top3_q) begin
										node_q <= PosW'(2); removed_q <= top2_q;
										onmax_q <= 1'b1;
									end else begin
										node_q <= PosW'(3); removed_q <= top3_q;
										onmax_q <= 1'b1;
									end
									st_q <= S_RM0;
								end
							end
						end
						default: begin
							removed_q <= '0;
							status_q <= StatusOk;
							st_q <= S_DONE;
						end
					endcase
				end
				// removal: read last, write to node, shrink
				S_RM0: st_q <= S_RM1;
				S_RM1: begin
					nv_q <= rdata_s1;
					pa_q <= node_q; vb_q <= rdata_s1; pb_q <= '0;
					cnt_q <= cnt_q - 1'b1;
					st_q <= S_WA; ret_q <= S_SCAN; sidx_q <= '0;
					best_q <= '0;
				end
				// sift down: scan children and grandchildren one read each
				S_SCAN: begin
					if (rdpend_q) begin
						rdpend_q <= 1'b0;
						if (best_q == 0 || outr(bv_q, rdata_s1, onmax_q)) begin
							best_q <= idx_q; bv_q <= rdata_s1;
						end
						if (cand_last) st_q <= S_DEC; else sidx_q <= sidx_q + 1'b1;
					end else if (cand_ok) begin
						idx_q <= cand; st_q <= S_RD; ret_q <= S_SCAN; rdpend_q <= 1'b1;
					end else st_q <= S_DEC;
				end
				S_RD: st_q <= ret_q;
				S_DEC: begin
					if (best_q == 0) st_q <= S_TOP0;
					else if (best_q >= {node_q, 2'b00}) begin
						if (!outr(nv_q, bv_q, onmax_q)) st_q <= S_TOP0;
						else begin
							pa_q <= node_q; vb_q <= bv_q; pb_q <= best_q; va_q <= nv_q;
							st_q <= S_WA; ret_q <= S_FIXW;
						end
					end else if (outr(nv_q, bv_q, onmax_q)) begin
						pa_q <= node_q; vb_q <= bv_q; pb_q <= best_q; va_q <= nv_q;
						st_q <= S_WA; ret_q <= S_TOP0;
					end else st_q <= S_TOP0;
				end
				// after grandchild swap: compare with its parent
				S_FIXW: begin
					if (!pend_q) begin
						idx_q <= best_q >> 1; st_q <= S_RD; ret_q <= S_FIXW; pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						node_q <= best_q; sidx_q <= '0; best_q <= '0;
						if (outr(nv_q, rdata_s1, onmax_q)) begin
							pa_q <= best_q; vb_q <= rdata_s1;
							pb_q <= best_q >> 1; va_q <= nv_q;
							nv_q <= rdata_s1;
							st_q <= S_WA; ret_q <= S_SCAN;
						end else st_q <= S_SCAN;
					end
				end
				S_WA: st_q <= (pb_q != 0) ? S_WB : ret_q;
				S_WB: st_q <= ret_q;
				// insert: fix against parent then climb grandparents
				S_FIXP: begin
					if (node_q == PosW'(1)) st_q <= S_TOP0;
					else if (!pend_q) begin
						idx_q <= node_q >> 1; st_q <= S_RD; ret_q <= S_FIXP; pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (lvl(node_q) % 2 == 0) begin
							if (rdata_s1 < nv_q) begin
								pa_q <= node_q >> 1; vb_q <= nv_q; pb_q <= node_q;
								va_q <= rdata_s1; node_q <= node_q >> 1;
								onmax_q <= 1'b1; st_q <= S_WA; ret_q <= S_UPCHK;
							end else begin
								onmax_q <= 1'b0; st_q <= S_UPCHK;
							end
						end else begin
							if (rdata_s1 > nv_q) begin
								pa_q <= node_q >> 1; vb_q <= nv_q; pb_q <= node_q;
								va_q <= rdata_s1; node_q <= node_q >> 1;
								onmax_q <= 1'b0; st_q <= S_WA; ret_q <= S_UPCHK;
							end else begin
								onmax_q <= 1'b1; st_q <= S_UPCHK;
							end
						end
					end
				end
				S_UPCHK: begin
					if ((node_q >> 2) == 0) st_q <= S_TOP0;
					else if (!pend_q) begin
						idx_q <= node_q >> 2; st_q <= S_RD; ret_q <= S_UPCHK; pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (outr(rdata_s1, nv_q, onmax_q)) begin
							pa_q <= node_q >> 2; vb_q <= nv_q; pb_q <= node_q;
							va_q <= rdata_s1; node_q <= node_q >> 2;
							st_q <= S_WA; ret_q <= S_UPCHK;
						end else st_q <= S_TOP0;
					end
				end
				S_TOP0: st_q <= S_DONE;
				S_DONE: if (out_load) begin
					out_q.removed_value <= removed_q;
					out_q.status <= status_q;
					out_q.min_value <= (cnt_q == 0) ? 32'sd0 : top1_q;
					out_q.max_value <= (cnt_q == 0) ? 32'sd0 :
						(cnt_q == 1) ? top1_q : (cnt_q == 2) ? top2_q :
						((top2_q > top3_q) ? top2_q : top3_q);
					out_q.is_empty <= (cnt_q == 0);
					out_q.entry_count <= cnt_q;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready = (st_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;
endmodule
`default_nettype wire

/* rtl/core/mmheap_checker.sv */
// Port-level checker for the min-max heap queue, bound to the top level.
// Depends on mmheap_pkg and the channel interfaces.
`default_nettype none
module mmheap_checker import mmheap_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire rsp_t out_payload
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("result dropped while stalled");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_payload.is_empty == (out_payload.entry_count == 0))
		else $error("empty flag mismatch");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_payload.is_empty |-> out_payload.min_value <= out_payload.max_value)
		else $error("min above max");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_payload.entry_count <= CountW'(Capacity))
		else $error("count over capacity");
endmodule

bind min_max_heap_double_ended_queue mmheap_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .out_payload(out_ch.payload)
);
`default_nettype wire
